/* design/nearest_color_value_lookup_core_macros.svh */
// Assertion macros shared by the nearest color value lookup design.
`ifndef NEAREST_COLOR_VALUE_LOOKUP_CORE_MACROS_SVH
`define NEAREST_COLOR_VALUE_LOOKUP_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that the consequent holds in the same cycle as the antecedent.
`define NCVL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest color lookup assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define NCVL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest color lookup assertion failed");

`else

`define NCVL_ASSERT_SAME(label, ante, cons)
`define NCVL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/ncvl_pkg.sv */
// Package with the shared types and constants of the nearest color value lookup.
package ncvl_pkg;

    localparam int IDX_W = 10;
    localparam int COL_W = 8;
    localparam int VAL_W = 16;
    localparam int CNT_W = 11;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

endpackage

/* design/ncvl_if.sv */
// Handshake interfaces for the command, result and configuration channels.
interface ncvl_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [ncvl_pkg::IDX_W-1:0]          entry_index;
    logic [ncvl_pkg::COL_W-1:0]          red;
    logic [ncvl_pkg::COL_W-1:0]          green;
    logic [ncvl_pkg::COL_W-1:0]          blue;
    logic signed [ncvl_pkg::VAL_W-1:0]   entry_value;

    modport source (output valid, kind, entry_index, red, green, blue, entry_value,
                    input ready);
    modport sink (input valid, kind, entry_index, red, green, blue, entry_value,
                  output ready);
endinterface

interface ncvl_res_if;
    logic                                valid;
    logic                                ready;
    logic [ncvl_pkg::IDX_W-1:0]          match_index;
    logic signed [ncvl_pkg::VAL_W-1:0]   result_value;
    logic                                black_pixel;

    modport source (output valid, match_index, result_value, black_pixel, input ready);
    modport sink (input valid, match_index, result_value, black_pixel, output ready);
endinterface

interface ncvl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ncvl_pkg::CNT_W-1:0]          palette_entries;

    modport source (output valid, palette_entries, input ready);
    modport sink (input valid, palette_entries, output ready);
endinterface

/* design/ncvl_dist.sv */
// Registered squared color distance between one palette entry and the query pixel.
module ncvl_dist #(
    parameter int EW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ncvl_pkg::tag_t               tag_in,
    input  logic [EW-1:0]                ent_red,
    input  logic [EW-1:0]                ent_green,
    input  logic [EW-1:0]                ent_blue,
    input  logic [ncvl_pkg::VAL_W-1:0]   ent_value,
    input  logic [EW-1:0]                pix_red,
    input  logic [EW-1:0]                pix_green,
    input  logic [EW-1:0]                pix_blue,
    output ncvl_pkg::tag_t               tag_out,
    output logic [2*EW+1:0]              sq_dist,
    output logic [ncvl_pkg::VAL_W-1:0]   value
);
    import ncvl_pkg::*;

    localparam int SW = 2 * EW + 2;

    logic [EW-1:0]   diff_r;
    logic [EW-1:0]   diff_g;
    logic [EW-1:0]   diff_b;
    logic [2*EW-1:0] sq_r;
    logic [2*EW-1:0] sq_g;
    logic [2*EW-1:0] sq_b;
    logic [SW-1:0]   sum_next;
    tag_t            tag_reg;
    logic [SW-1:0]   dist_reg;
    logic [VAL_W-1:0] value_reg;

    always_comb
    begin
        diff_r   = (ent_red > pix_red) ? ent_red - pix_red : pix_red - ent_red;
        diff_g   = (ent_green > pix_green) ? ent_green - pix_green : pix_green - ent_green;
        diff_b   = (ent_blue > pix_blue) ? ent_blue - pix_blue : pix_blue - ent_blue;
        sq_r     = (2*EW)'(diff_r) * (2*EW)'(diff_r);
        sq_g     = (2*EW)'(diff_g) * (2*EW)'(diff_g);
        sq_b     = (2*EW)'(diff_b) * (2*EW)'(diff_b);
        sum_next = SW'(sq_r) + SW'(sq_g) + SW'(sq_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= sum_next;
        value_reg <= ent_value;
    end

    assign tag_out = tag_reg;
    assign sq_dist = dist_reg;
    assign value   = value_reg;

endmodule

/* design/nearest_color_value_lookup_core.sv */
// Top level of the nearest color value lookup: palette memory, scan control and result register.
// A write item stores one palette entry. A query item scans entries 0 to palette_entries-1
// through the single read port of the palette memory, one entry per cycle, and its result
// item passes the read, distance, best-match, done and output registers before it is shown (a
// count of zero scans one entry, a count above the depth scans the whole palette).
// The nearest entry by squared RGB distance wins, the lowest index on ties, and a pure black
// pixel returns value zero. The next item is accepted as soon as the result sits in the output
// register, even while it waits to be taken.
`include "nearest_color_value_lookup_core_macros.svh"

module nearest_color_value_lookup_core #(
    parameter int PALETTE_DEPTH = 1024,
    parameter int COLOR_BITS    = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ncvl_cfg_if.sink     cfg,
    ncvl_cmd_if.sink     cmd,
    ncvl_res_if.source   res
);
    import ncvl_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int EW = (COLOR_BITS < COL_W) ? COLOR_BITS : COL_W;
    localparam int DW = 2 * EW + 2;
    localparam int WW = 3 * EW + VAL_W;

    logic [WW-1:0]    palette_mem [PALETTE_DEPTH];

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cfg_reg;
    logic [AW-1:0]    scan_reg;
    logic [AW-1:0]    last_reg;
    logic [EW-1:0]    pix_r_reg;
    logic [EW-1:0]    pix_g_reg;
    logic [EW-1:0]    pix_b_reg;
    logic [WW-1:0]    rdata_reg;
    tag_t             rd_tag_reg;
    tag_t             dist_tag;
    logic [DW-1:0]    entry_dist;
    logic [VAL_W-1:0] dist_value;
    logic [AW-1:0]    cmp_idx_reg;
    logic [AW-1:0]    cmp_idx_next;
    logic [DW-1:0]    best_d_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [VAL_W-1:0] best_val_reg;
    logic             done_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [IDX_W-1:0] res_idx_reg;
    logic [VAL_W-1:0] res_val_reg;
    logic             res_black_reg;

    logic             cmd_ready;
    logic             rd_en;
    logic             load_out;
    logic             cmd_fire;
    logic             mem_we;
    logic [31:0]      widx_32;
    logic [31:0]      cnt_32;
    logic [31:0]      best_32;
    logic [AW-1:0]    last_next;
    logic             pix_black;

    assign cfg.ready = 1'b1;
    assign cmd.ready = cmd_ready;
    assign cmd_fire  = cmd.valid && cmd_ready;
    assign widx_32   = 32'(cmd.entry_index);
    assign mem_we    = cmd_fire && (cmd.kind == KIND_WRITE) && (widx_32 < 32'(PALETTE_DEPTH));

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cnt_32 = 32'd1;
        end
        else if (32'(cfg_reg) > 32'(PALETTE_DEPTH))
        begin
            cnt_32 = 32'(PALETTE_DEPTH);
        end
        else
        begin
            cnt_32 = 32'(cfg_reg);
        end
        last_next = AW'(cnt_32 - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CNT_W'(1);
        end
        else if (cfg.valid)
        begin
            cfg_reg <= cfg.palette_entries;
        end
    end

    // Next-state logic of the scan sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.kind == KIND_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == last_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (done_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode of the scan sequencer.
    always_comb
    begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            ST_WAIT:
            begin
                rd_en = 1'b0;
            end
            ST_OUT:
            begin
                load_out = !res_valid_reg || res.ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Writes are taken only while idle and reads happen only while scanning, so the two
    // never touch the memory in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[widx_32[AW-1:0]] <= {cmd.red[EW-1:0], cmd.green[EW-1:0],
                                             cmd.blue[EW-1:0], cmd.entry_value};
        end
        if (rd_en)
        begin
            rdata_reg <= palette_mem[scan_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.kind == KIND_QUERY))
        begin
            pix_r_reg <= cmd.red[EW-1:0];
            pix_g_reg <= cmd.green[EW-1:0];
            pix_b_reg <= cmd.blue[EW-1:0];
            last_reg  <= last_next;
            scan_reg  <= '0;
        end
        else if (rd_en)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg.valid <= rd_en;
            rd_tag_reg.first <= rd_en && (scan_reg == '0);
            rd_tag_reg.last  <= rd_en && (scan_reg == last_reg);
        end
    end

    ncvl_dist #(
        .EW (EW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (rd_tag_reg),
        .ent_red   (rdata_reg[WW-1 -: EW]),
        .ent_green (rdata_reg[WW-EW-1 -: EW]),
        .ent_blue  (rdata_reg[WW-2*EW-1 -: EW]),
        .ent_value (rdata_reg[VAL_W-1:0]),
        .pix_red   (pix_r_reg),
        .pix_green (pix_g_reg),
        .pix_blue  (pix_b_reg),
        .tag_out   (dist_tag),
        .sq_dist   (entry_dist),
        .value     (dist_value)
    );

    assign cmp_idx_next = dist_tag.first ? '0 : cmp_idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (dist_tag.valid)
        begin
            cmp_idx_reg <= cmp_idx_next;
            if (dist_tag.first || (entry_dist < best_d_reg))
            begin
                best_d_reg   <= entry_dist;
                best_idx_reg <= cmp_idx_next;
                best_val_reg <= dist_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dist_tag.valid && dist_tag.last;
        end
    end

    assign pix_black      = (pix_r_reg == '0) && (pix_g_reg == '0) && (pix_b_reg == '0);
    assign best_32        = 32'(best_idx_reg);
    assign res_valid_next = load_out ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_idx_reg   <= best_32[IDX_W-1:0];
            res_val_reg   <= pix_black ? '0 : best_val_reg;
            res_black_reg <= pix_black;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.match_index  = res_idx_reg;
    assign res.result_value = res_val_reg;
    assign res.black_pixel  = res_black_reg;

    `NCVL_ASSERT_SAME(a_write_while_idle, mem_we, state_reg == ST_IDLE && !rd_en)
    `NCVL_ASSERT_SAME(a_done_while_waiting, done_reg, state_reg == ST_WAIT)
    `NCVL_ASSERT_SAME(a_compare_not_idle, dist_tag.valid, state_reg == ST_SCAN || state_reg == ST_WAIT)
    `NCVL_ASSERT_NEXT(a_load_shows_result, load_out, res.valid && state_reg == ST_IDLE)

endmodule

/* dv/nearest_color_value_lookup_core_tb.sv */
// Testbench for the nearest color value lookup core: palette writes and pixel queries checked against a built-in predictor.
module nearest_color_value_lookup_core_tb;
    import ncvl_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 50000;

    typedef struct {
        logic                    kind;
        logic [IDX_W-1:0]        entry_index;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic signed [VAL_W-1:0] entry_value;
    } pixel_item_t;

    typedef struct {
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic signed [VAL_W-1:0] value;
    } palette_entry_t;

    typedef struct {
        logic [IDX_W-1:0]        match_index;
        logic signed [VAL_W-1:0] result_value;
        logic                    black_pixel;
    } color_match_t;

    logic clk;
    logic rst_n;

    ncvl_cmd_if cmd_if ();
    ncvl_res_if res_if ();
    ncvl_cfg_if cfg_if ();

    nearest_color_value_lookup_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    palette_entry_t   palette_copy [DEPTH];
    logic [CNT_W-1:0] entry_count;
    color_match_t     pending_matches [$];
    int               error_count;
    int               lost_count;
    int               write_total;
    int               query_total;
    int               black_total;
    int               count_writes;
    bit               steady;
    bit               hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned scan_length();
        int unsigned n;
        n = 32'(entry_count);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    function automatic color_match_t nearest_match(input logic [COL_W-1:0] r,
                                                   input logic [COL_W-1:0] g,
                                                   input logic [COL_W-1:0] b);
        color_match_t m;
        int unsigned  n;
        int unsigned  best;
        int unsigned  best_d;
        int unsigned  d;
        int           dr;
        int           dg;
        int           db;
        n = scan_length();
        best = 0;
        best_d = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            dr = int'(palette_copy[i].red) - int'(r);
            dg = int'(palette_copy[i].green) - int'(g);
            db = int'(palette_copy[i].blue) - int'(b);
            d = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        m.match_index = best[IDX_W-1:0];
        m.black_pixel = (r == 0 && g == 0 && b == 0);
        m.result_value = m.black_pixel ? '0 : palette_copy[best].value;
        return m;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        int v;
        v = int'($urandom_range(0, 32768)) - 16384;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] rand_color();
        return COL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [COL_W-1:0] nudge(input logic [COL_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[COL_W-1:0];
    endfunction

    function automatic pixel_item_t write_item(input logic [IDX_W-1:0] idx,
                                               input logic [COL_W-1:0] r,
                                               input logic [COL_W-1:0] g,
                                               input logic [COL_W-1:0] b,
                                               input logic signed [VAL_W-1:0] v);
        pixel_item_t item;
        item.kind = KIND_WRITE;
        item.entry_index = idx;
        item.red = r;
        item.green = g;
        item.blue = b;
        item.entry_value = v;
        return item;
    endfunction

    function automatic pixel_item_t query_item(input logic [COL_W-1:0] r,
                                               input logic [COL_W-1:0] g,
                                               input logic [COL_W-1:0] b);
        pixel_item_t item;
        item = write_item(IDX_W'($urandom_range(0, DEPTH - 1)), r, g, b, rand_value());
        item.kind = KIND_QUERY;
        return item;
    endfunction

    task automatic send_item(input pixel_item_t item);
        int unsigned gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= item.kind;
        cmd_if.entry_index <= item.entry_index;
        cmd_if.red         <= item.red;
        cmd_if.green       <= item.green;
        cmd_if.blue        <= item.blue;
        cmd_if.entry_value <= item.entry_value;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        if (item.kind == KIND_WRITE)
        begin
            palette_copy[item.entry_index].red   = item.red;
            palette_copy[item.entry_index].green = item.green;
            palette_copy[item.entry_index].blue  = item.blue;
            palette_copy[item.entry_index].value = item.entry_value;
            write_total++;
        end
        else
        begin
            pending_matches.push_back(nearest_match(item.red, item.green, item.blue));
            query_total++;
            if (item.red == 0 && item.green == 0 && item.blue == 0)
                black_total++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [CNT_W-1:0] n);
        wait_idle();
        @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.palette_entries <= n;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        entry_count = n;
        count_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_default_count();
        send_item(write_item(0, 37, 200, 90, 5000));
        send_item(write_item(5, 1, 2, 3, -5000));
        send_item(query_item(255, 255, 255));
        send_item(query_item(0, 0, 0));
        send_item(query_item(37, 200, 90));
    endtask

    task automatic test_extreme_colors();
        set_entry_count(8);
        send_item(write_item(0, 0, 0, 0, -16384));
        send_item(write_item(1, 255, 255, 255, 16384));
        send_item(write_item(2, 255, 0, 0, 0));
        send_item(write_item(3, 255, 0, 0, -1));
        send_item(write_item(4, 0, 255, 0, 1234));
        send_item(write_item(5, 0, 0, 255, -4321));
        send_item(write_item(6, 100, 100, 100, 16383));
        send_item(write_item(7, 110, 100, 100, 8192));
        send_item(query_item(255, 255, 255));
        send_item(query_item(0, 0, 0));
        send_item(query_item(255, 0, 0));
        send_item(query_item(105, 100, 100));
        send_item(query_item(0, 0, 1));
        send_item(query_item(0, 255, 0));
        send_item(query_item(0, 0, 255));
    endtask

    task automatic test_count_zero();
        set_entry_count(0);
        send_item(query_item(rand_color(), rand_color(), rand_color()));
        send_item(query_item(0, 0, 0));
    endtask

    task automatic test_full_palette();
        for (int i = 0; i < DEPTH; i++)
        begin
            steady = (i < DEPTH / 2);
            send_item(write_item(IDX_W'(i), rand_color(), rand_color(), rand_color(),
                                 rand_value()));
        end
        steady = 1'b0;
        set_entry_count(CNT_W'(DEPTH));
        send_item(query_item(rand_color(), rand_color(), rand_color()));
        send_item(query_item(palette_copy[DEPTH-1].red, palette_copy[DEPTH-1].green,
                             palette_copy[DEPTH-1].blue));
        set_entry_count('1);
        send_item(query_item(rand_color(), rand_color(), rand_color()));
        send_item(query_item(0, 0, 0));
    endtask

    task automatic test_random_phases();
        pixel_item_t      item;
        palette_entry_t   ref_entry;
        logic [CNT_W-1:0] count;
        int unsigned      n;
        int unsigned      pick;
        int unsigned      j;
        for (int phase = 0; phase < 8; phase++)
        begin
            if ($urandom_range(0, 99) < 70)
                count = CNT_W'($urandom_range(2, 24));
            else
                count = CNT_W'($urandom_range(25, 96));
            if (phase == 0)
                count = CNT_W'(1);
            set_entry_count(count);
            steady = (phase % 4 == 1);
            n = scan_length();
            for (int k = 0; k < 50; k++)
            begin
                pick = $urandom_range(0, 99);
                j = $urandom_range(0, n - 1);
                ref_entry = palette_copy[j];
                if (pick < 40)
                begin
                    item = write_item(($urandom_range(0, 3) != 0) ? IDX_W'(j)
                                          : IDX_W'($urandom_range(0, DEPTH - 1)),
                                      rand_color(), rand_color(), rand_color(),
                                      rand_value());
                    if ($urandom_range(0, 4) == 0)
                    begin
                        ref_entry = palette_copy[$urandom_range(0, n - 1)];
                        item.red = ref_entry.red;
                        item.green = ref_entry.green;
                        item.blue = ref_entry.blue;
                    end
                end
                else if (pick < 65)
                    item = query_item(rand_color(), rand_color(), rand_color());
                else if (pick < 80)
                    item = query_item(ref_entry.red, ref_entry.green, ref_entry.blue);
                else if (pick < 90)
                    item = query_item(nudge(ref_entry.red), nudge(ref_entry.green),
                                      nudge(ref_entry.blue));
                else if (pick < 95)
                    item = query_item(0, 0, 0);
                else
                    item = query_item($urandom_range(0, 1) ? 8'd255 : 8'd0,
                                      $urandom_range(0, 1) ? 8'd255 : 8'd0,
                                      $urandom_range(0, 1) ? 8'd255 : 8'd0);
                send_item(item);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_output_stall();
        set_entry_count(4);
        steady = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_item(query_item(rand_color(), rand_color(), rand_color()));
        steady = 1'b0;
    endtask

    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_taken;
        stall_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20)
                    stall_left = gap_len();
            end
        end
    end

    initial
    begin
        color_match_t want;
        error_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("result item arrived with no query waiting");
                    error_count++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (res_if.match_index !== want.match_index)
                    begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, res_if.match_index);
                        error_count++;
                    end
                    if (res_if.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, res_if.result_value);
                        error_count++;
                    end
                    if (res_if.black_pixel !== want.black_pixel)
                    begin
                        $error("black_pixel: expected %0d, got %0d",
                               want.black_pixel, res_if.black_pixel);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned waited;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.kind = KIND_WRITE;
        cmd_if.entry_index = '0;
        cmd_if.red = '0;
        cmd_if.green = '0;
        cmd_if.blue = '0;
        cmd_if.entry_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.palette_entries = '0;
        entry_count = CNT_W'(1);
        steady = 1'b0;
        hold_req = 1'b0;
        lost_count = 0;
        write_total = 0;
        query_total = 0;
        black_total = 0;
        count_writes = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_count();
        test_extreme_colors();
        test_count_zero();
        test_full_palette();
        test_random_phases();
        test_output_stall();

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        waited = 0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (scan_length() + 8) @(posedge clk);
        if (pending_matches.size() != 0)
        begin
            $error("%0d expected result items never arrived", pending_matches.size());
            lost_count = pending_matches.size();
        end
        $display("Run covered %0d palette writes and %0d pixel queries, %0d of them black,",
                 write_total, query_total, black_total);
        $display("across %0d entry count settings from zero up to the full palette.",
                 count_writes);
        if (error_count == 0 && lost_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
